FILE: rtl/rlc_pkg.sv
package rlc_pkg;

    // Longest run that the encoder gathers before it closes the run.
    localparam int MAX_RUN = 99;

    // Character code of the digit zero.
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // Entries in the command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic [6:0] t_len;

    // One command for the back: optional tens and ones digits, then the
    // symbol repeated count times. The flags belong to its final result.
    typedef struct packed {
        logic [7:0] sym;
        logic       show_tens;
        logic       show_ones;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [3:0] count;
        logic       last_item;
        logic       last_string;
    } t_cmd;

    // Build the command that emits one closed run of the encoder.
    // The tens digit comes from a multiply by the reciprocal of ten,
    // which is exact over the seven-bit run length.
    function automatic t_cmd make_run(input logic [7:0] sym, input t_len len,
                                      input logic last_item, input logic last_string);
        t_cmd       c;
        logic [14:0] prod;
        logic [3:0] tens;
        logic [7:0] tens_x10;
        prod     = 15'({8'd0, len} * 15'd205);
        tens     = prod[14:11];
        tens_x10 = 8'({4'd0, tens} * 8'd10);
        c.sym         = sym;
        c.show_tens   = (len >= t_len'(10));
        c.show_ones   = (len > t_len'(1));
        c.tens        = tens;
        c.ones        = 4'({1'b0, len} - tens_x10);
        c.count       = 4'd1;
        c.last_item   = last_item;
        c.last_string = last_string;
        return c;
    endfunction

endpackage

FILE: rtl/rlc_front.sv
module rlc_front
    import rlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_decode_mode,
    input  logic       i_valid,
    input  logic [7:0] i_symbol,
    input  logic       i_string_end,
    output logic       o_ready,
    output logic       o_q_valid,
    output t_cmd       o_q_cmd,
    input  logic       i_q_ready
);

    logic       r_mode;
    logic [7:0] r_held;
    t_len       r_len;
    logic       r_have;
    logic [3:0] r_rep;
    logic       r_pend;
    t_cmd       r_pend_cmd;

    logic       n_mode;
    logic [7:0] n_held;
    t_len       n_len;
    logic       n_have;
    logic [3:0] n_rep;
    logic       n_pend;
    t_cmd       n_pend_cmd;

    logic       accept;
    logic       is_digit;
    logic       diff;
    logic       start;
    t_len       len_new;
    logic       close;
    logic [7:0] run_sym;
    t_cmd       cmd_a;
    t_cmd       cmd_b;
    t_cmd       cmd_rep;

    // A request is taken only when no second command waits and the queue has room.
    assign o_ready = !r_pend && i_q_ready;
    assign accept  = i_valid && o_ready;

    // Classify the incoming character against the open run.
    always_comb begin
        is_digit = (i_symbol >= CHAR_ZERO) && (i_symbol <= (CHAR_ZERO + 8'd9));
        diff     = r_have && (i_symbol != r_held);
        start    = !r_have || diff;
        len_new  = start ? t_len'(1) : t_len'(r_len + t_len'(1));
        close    = (len_new >= t_len'(MAX_RUN)) || i_string_end;
        run_sym  = start ? i_symbol : r_held;
        cmd_a    = make_run(r_held, r_len, !close, 1'b0);
        cmd_b    = make_run(run_sym, len_new, 1'b1, i_string_end);
        cmd_rep             = '0;
        cmd_rep.sym         = i_symbol;
        cmd_rep.count       = r_rep;
        cmd_rep.last_item   = 1'b1;
        cmd_rep.last_string = i_string_end;
    end

    // Push commands and advance the codec state.
    always_comb begin
        n_mode     = r_mode;
        n_held     = r_held;
        n_len      = r_len;
        n_have     = r_have;
        n_rep      = r_rep;
        n_pend     = r_pend;
        n_pend_cmd = r_pend_cmd;
        o_q_valid  = 1'b0;
        o_q_cmd    = r_pend_cmd;

        if (i_cfg_valid) begin
            n_mode = i_cfg_decode_mode;
        end

        if (r_pend) begin
            o_q_valid = 1'b1;
            if (i_q_ready) begin
                n_pend = 1'b0;
            end
        end else if (accept) begin
            if (r_mode) begin
                if (is_digit) begin
                    n_rep = i_string_end ? 4'd1 : 4'(i_symbol - CHAR_ZERO);
                end else begin
                    n_rep = 4'd1;
                    if (r_rep != 4'd0) begin
                        o_q_valid = 1'b1;
                        o_q_cmd   = cmd_rep;
                    end
                end
            end else begin
                if (diff) begin
                    o_q_valid = 1'b1;
                    o_q_cmd   = cmd_a;
                    if (close) begin
                        n_pend     = 1'b1;
                        n_pend_cmd = cmd_b;
                    end
                end else if (close) begin
                    o_q_valid = 1'b1;
                    o_q_cmd   = cmd_b;
                end
                n_held = run_sym;
                if (close) begin
                    n_have = 1'b0;
                    n_len  = t_len'(0);
                end else begin
                    n_have = 1'b1;
                    n_len  = len_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_held <= 8'd0;
            r_len  <= t_len'(0);
            r_have <= 1'b0;
            r_rep  <= 4'd1;
            r_pend <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_len  <= n_len;
            r_have <= n_have;
            r_rep  <= n_rep;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_cmd <= n_pend_cmd;
    end

endmodule

FILE: rtl/rlc_queue.sv
module rlc_queue
    import rlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [CNT_W-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != CNT_W'(0));
    assign o_cmd        = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: rtl/rlc_back.sv
module rlc_back
    import rlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    output logic       o_valid,
    output logic [7:0] o_out_symbol,
    output logic       o_last_of_item,
    output logic       o_last_of_string,
    input  logic       i_ready
);

    logic r_busy;
    t_cmd r_cmd;

    logic take;
    logic last_of_cmd;

    assign take        = o_valid && i_ready;
    assign last_of_cmd = !r_cmd.show_tens && !r_cmd.show_ones && (r_cmd.count == 4'd1);
    assign o_cmd_ready = !r_busy || (take && last_of_cmd);

    // The current result follows from what is left of the held command.
    always_comb begin
        o_valid = r_busy;
        if (r_cmd.show_tens) begin
            o_out_symbol = CHAR_ZERO + {4'd0, r_cmd.tens};
        end else if (r_cmd.show_ones) begin
            o_out_symbol = CHAR_ZERO + {4'd0, r_cmd.ones};
        end else begin
            o_out_symbol = r_cmd.sym;
        end
        o_last_of_item   = last_of_cmd && r_cmd.last_item;
        o_last_of_string = last_of_cmd && r_cmd.last_string;
    end

    // Busy flag: a command is held until its final result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_cmd_ready) begin
            r_busy <= i_cmd_valid;
        end
    end

    // Step through the digits, then through the symbol repeats.
    always_ff @(posedge i_clk) begin
        if (o_cmd_ready) begin
            r_cmd <= i_cmd;
        end else if (take) begin
            if (r_cmd.show_tens) begin
                r_cmd.show_tens <= 1'b0;
            end else if (r_cmd.show_ones) begin
                r_cmd.show_ones <= 1'b0;
            end else begin
                r_cmd.count <= r_cmd.count - 4'd1;
            end
        end
    end

endmodule

FILE: rtl/run_length_codec.sv
// Run-length encoder and decoder, one character per request.
// Each command passes through the command queue, then the back's command register.
// Throughput: one result per cycle from the back while i_ready is high; a request is
// accepted each cycle while the front holds no command and the two-entry queue has room.
// Sustained rate follows the result count: up to four per request encoding, nine decoding.
// Reset: synchronous active low; encode mode, no open run, repeat count one, queue empty.
module run_length_codec
    import rlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_decode_mode,
    output logic       o_cfg_ready,
    input  logic       i_valid,
    input  logic [7:0] i_symbol,
    input  logic       i_string_end,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_out_symbol,
    output logic       o_last_of_item,
    output logic       o_last_of_string,
    input  logic       i_ready
);

    logic q_in_valid;
    t_cmd q_in_cmd;
    logic q_in_ready;
    logic q_out_valid;
    t_cmd q_out_cmd;
    logic q_out_ready;

    // The mode register is written at any time it is offered.
    assign o_cfg_ready = 1'b1;

    rlc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_decode_mode (i_cfg_decode_mode),
        .i_valid           (i_valid),
        .i_symbol          (i_symbol),
        .i_string_end      (i_string_end),
        .o_ready           (o_ready),
        .o_q_valid         (q_in_valid),
        .o_q_cmd           (q_in_cmd),
        .i_q_ready         (q_in_ready)
    );

    rlc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_in_valid),
        .i_cmd        (q_in_cmd),
        .o_push_ready (q_in_ready),
        .o_pop_valid  (q_out_valid),
        .o_cmd        (q_out_cmd),
        .i_pop        (q_out_ready)
    );

    rlc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_out_valid),
        .i_cmd            (q_out_cmd),
        .o_cmd_ready      (q_out_ready),
        .o_valid          (o_valid),
        .o_out_symbol     (o_out_symbol),
        .o_last_of_item   (o_last_of_item),
        .o_last_of_string (o_last_of_string),
        .i_ready          (i_ready)
    );

endmodule

FILE: rtl/rlc_checker.sv
module rlc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_valid,
    input logic [7:0] i_symbol,
    input logic       i_string_end,
    input logic       o_ready,
    input logic       o_valid,
    input logic [7:0] o_out_symbol,
    input logic       o_last_of_item,
    input logic       o_last_of_string,
    input logic       i_ready
);

    // A stalled result holds its value and its flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_symbol)
            && $stable(o_last_of_item) && $stable(o_last_of_string))
        else $error("stalled result changed");

    // A waiting request keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_symbol) && $stable(i_string_end))
        else $error("waiting request changed");

    // The end of a string is always the end of the request's results.
    a_string_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_string |-> o_last_of_item)
        else $error("string end without request end");

    // Nothing is shown right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The mode register never refuses a write.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("mode write refused");

endmodule

bind run_length_codec rlc_checker u_rlc_checker (.*);

FILE: tb/sv/rlc_result_check.sv
`timescale 1ns / 1ps

// Watches the configuration, request and result channels of the codec, keeps
// its own copy of the codec state and compares every result with the oldest
// symbol still owed.
module rlc_result_check
    import rlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_decode_mode,
    input  logic       i_cfg_ready,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_symbol,
    input  logic       i_in_string_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_symbol,
    input  logic       i_out_last_of_item,
    input  logic       i_out_last_of_string,
    output int         o_fail_count,
    output int         o_pending
);

    // One emitted character with its two end markers.
    typedef struct packed {
        logic [7:0] sym;
        logic       last_item;
        logic       last_string;
    } t_emit;

    t_emit owed_symbols[$];
    t_emit step_symbols[$];

    // Shadow state of the codec.
    logic       decode_on;
    logic [7:0] run_char;
    t_len       run_len;
    logic       run_open;
    logic [3:0] repeat_n;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic push_symbol(input logic [7:0] sym);
        t_emit e;
        e = '{sym, 1'b0, 1'b0};
        step_symbols.insert(step_symbols.size(), e);
    endtask

    // A closed run goes out as its decimal length, when above one, then its character.
    task automatic close_run();
        if (run_len > t_len'(1)) begin
            if (run_len >= t_len'(10)) begin
                push_symbol(CHAR_ZERO + 8'(run_len / t_len'(10)));
            end
            push_symbol(CHAR_ZERO + 8'(run_len % t_len'(10)));
        end
        push_symbol(run_char);
        run_open = 1'b0;
        run_len  = '0;
    endtask

    // Work out the characters that one accepted request owes and queue them.
    task automatic codec_step(input logic [7:0] sym, input logic s_end);
        t_emit tail;
        step_symbols.delete();
        if (decode_on) begin
            if (sym >= CHAR_ZERO && sym <= CHAR_ZERO + 8'd9) begin
                repeat_n = 4'(sym - CHAR_ZERO);
            end else begin
                for (int k = 0; k < int'(repeat_n); k++) begin
                    push_symbol(sym);
                end
                repeat_n = 4'd1;
            end
            if (s_end) begin
                repeat_n = 4'd1;
            end
        end else begin
            if (run_open && sym != run_char) begin
                close_run();
            end
            if (!run_open) begin
                run_char = sym;
                run_len  = t_len'(1);
                run_open = 1'b1;
            end else begin
                run_len = run_len + t_len'(1);
            end
            if (run_len >= t_len'(MAX_RUN) || s_end) begin
                close_run();
            end
        end
        // The markers sit on the final character of the request.
        if (step_symbols.size() > 0) begin
            tail = step_symbols.pop_back();
            tail.last_item   = 1'b1;
            tail.last_string = s_end;
            step_symbols.insert(step_symbols.size(), tail);
        end
        foreach (step_symbols[i]) begin
            owed_symbols.insert(owed_symbols.size(), step_symbols[i]);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_emit want;
        if (!i_rst_n) begin
            decode_on    = 1'b0;
            run_char     = '0;
            run_len      = '0;
            run_open     = 1'b0;
            repeat_n     = 4'd1;
            o_fail_count = 0;
            owed_symbols.delete();
        end else begin
            // A request at the same edge as a mode write still sees the old mode.
            if (i_in_valid && i_in_ready) begin
                codec_step(i_in_symbol, i_in_string_end);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                decode_on = i_cfg_decode_mode;
            end
            // Each result is checked field by field against the oldest owed symbol.
            if (i_out_valid && i_out_ready) begin
                if (owed_symbols.size() == 0) begin
                    report_mismatch($sformatf("result %02h with nothing owed", i_out_symbol));
                end else begin
                    want = owed_symbols.pop_front();
                    if (i_out_symbol !== want.sym) begin
                        report_mismatch($sformatf("symbol %02h, wanted %02h",
                                                  i_out_symbol, want.sym));
                    end
                    if (i_out_last_of_item !== want.last_item) begin
                        report_mismatch($sformatf("last_of_item %b, wanted %b on symbol %02h",
                                                  i_out_last_of_item, want.last_item, want.sym));
                    end
                    if (i_out_last_of_string !== want.last_string) begin
                        report_mismatch($sformatf("last_of_string %b, wanted %b on symbol %02h",
                                                  i_out_last_of_string, want.last_string,
                                                  want.sym));
                    end
                end
            end
        end
        o_pending = owed_symbols.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rlc_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 14;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [7:0] CHAR_A = 8'h41;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       cfg_valid       = 1'b0;
    logic       cfg_decode_mode = 1'b0;
    logic       cfg_ready;
    logic       in_valid        = 1'b0;
    logic [7:0] in_symbol       = '0;
    logic       in_string_end   = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_symbol;
    logic       out_last_item;
    logic       out_last_string;
    logic       out_ready       = 1'b0;

    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   phase_items = 0;
    logic hold_req    = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   fail_count;
    int   pending;

    always #2 clk = ~clk;

    run_length_codec dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_decode_mode(cfg_decode_mode),
        .o_cfg_ready      (cfg_ready),
        .i_valid          (in_valid),
        .i_symbol         (in_symbol),
        .i_string_end     (in_string_end),
        .o_ready          (in_ready),
        .o_valid          (out_valid),
        .o_out_symbol     (out_symbol),
        .o_last_of_item   (out_last_item),
        .o_last_of_string (out_last_string),
        .i_ready          (out_ready)
    );

    rlc_result_check u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_decode_mode   (cfg_decode_mode),
        .i_cfg_ready         (cfg_ready),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_in_symbol         (in_symbol),
        .i_in_string_end     (in_string_end),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_out_symbol        (out_symbol),
        .i_out_last_of_item  (out_last_item),
        .i_out_last_of_string(out_last_string),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // Result side: random stalls, or a long hold-off after each toggle of hold_req.
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one request, with random gaps first, and wait until it is taken.
    task automatic send_item(input logic [7:0] sym, input logic s_end);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_symbol     <= sym;
        in_string_end <= s_end;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        phase_items++;
    endtask

    task automatic send_run(input logic [7:0] sym, input int len, input logic close);
        for (int i = 0; i < len; i++) begin
            send_item(sym, close && i == len - 1);
        end
    endtask

    // Stop offering and wait until every owed result has come, plus a settle time.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic decode);
        drain();
        cfg_valid       <= 1'b1;
        cfg_decode_mode <= decode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a few uppercase letters so runs form, sometimes digits or any byte.
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return CHAR_A + 8'($urandom_range(0, 3));
        end else if (r < 75) begin
            return CHAR_A + 8'($urandom_range(0, 25));
        end else if (r < 85) begin
            return CHAR_ZERO + 8'($urandom_range(0, 9));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // A string of runs; now and then it is left open so the run carries on.
    task automatic random_encode_string();
        int   runs;
        int   len;
        int   r;
        logic close;
        runs  = $urandom_range(1, 5);
        close = ($urandom_range(0, 99) < 85);
        for (int i = 0; i < runs; i++) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                len = $urandom_range(1, 4);
            end else if (r < 97) begin
                len = $urandom_range(5, 15);
            end else begin
                len = $urandom_range(MAX_RUN - 4, MAX_RUN + 2);
            end
            send_run(pick_symbol(), len, close && i == runs - 1);
        end
    endtask

    // Mostly count-letter pairs, with bare letters, double digits, trailing digits and noise.
    task automatic random_decode_string();
        int   parts;
        int   r;
        logic close;
        logic tail;
        parts = $urandom_range(1, 5);
        close = ($urandom_range(0, 99) < 85);
        for (int i = 0; i < parts; i++) begin
            tail = close && i == parts - 1;
            r    = $urandom_range(0, 99);
            if (r < 60) begin
                send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                send_item(CHAR_A + 8'($urandom_range(0, 25)), tail);
            end else if (r < 70) begin
                send_item(CHAR_A + 8'($urandom_range(0, 25)), tail);
            end else if (r < 80) begin
                send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                send_item(CHAR_A + 8'($urandom_range(0, 25)), tail);
            end else if (r < 90) begin
                send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), tail);
            end else begin
                send_item(8'($urandom_range(0, 255)), tail);
            end
        end
    endtask

    // Hard stop in case the codec hangs.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed encode: single run, run change, digits, byte extremes, open run.
        write_mode(1'b0);
        send_item("A", 1'b1);
        send_run("B", 2, 1'b0);
        send_item("C", 1'b1);
        send_run("5", 3, 1'b1);
        send_run(8'hFF, 2, 1'b1);
        send_item(8'h00, 1'b1);
        send_run("Q", 2, 1'b0);

        // Directed decode: counts, count zero, count nine, digit range edges,
        // string end on a digit. The open encode run must survive this.
        write_mode(1'b1);
        send_item("3", 1'b0);
        send_item("X", 1'b0);
        send_item("0", 1'b0);
        send_item("Y", 1'b0);
        send_item("9", 1'b0);
        send_item(8'hFF, 1'b1);
        send_item("/", 1'b0);
        send_item("4", 1'b1);
        send_item(":", 1'b1);

        // Back to encode: the held run continues.
        write_mode(1'b0);
        send_item("Q", 1'b1);

        // Random phases alternate the mode and step through the idling styles.
        for (int p = 0; p < 8; p++) begin
            write_mode(1'(p % 2));
            case (p / 2)
                0: begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  = 47;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct <= 47;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct <= 33;
                end
            endcase
            // One run past the cap so it is cut and a new run begins.
            if (p == 0) begin
                send_run("Z", MAX_RUN + 1, 1'b1);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (p % 2 == 1) begin
                    random_decode_string();
                end else begin
                    random_encode_string();
                end
            end
        end

        // Back pressure: results held off while nine-fold expansions keep coming.
        write_mode(1'b1);
        idle_pct  = 0;
        stall_pct <= 0;
        hold_req  <= ~hold_req;
        for (int i = 0; i < 15; i++) begin
            send_item("9", 1'b0);
            send_item(CHAR_A + 8'($urandom_range(0, 25)), 1'b0);
        end
        drain();
        for (int i = 0; i < 5; i++) begin
            send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            send_item(CHAR_A + 8'($urandom_range(0, 25)), i == 4);
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: run_length_codec.f
rtl/rlc_pkg.sv
rtl/rlc_front.sv
rtl/rlc_queue.sv
rtl/rlc_back.sv
rtl/run_length_codec.sv
rtl/rlc_checker.sv
tb/sv/rlc_result_check.sv
tb/sv/tb.sv
